/* sv/pfg_pkg.sv */
// ----------------------------------------------------------------------------
// pfg_pkg
// Shared types, constants and register indexes for the PPM frame generator.
// ----------------------------------------------------------------------------
package pfg_pkg;

  // Frame geometry
  localparam int CHANNELS   = 4;
  localparam int COUNT_BITS = 16;
  localparam int SLOTS      = CHANNELS + 2;
  localparam int SLOT_BITS  = $clog2(SLOTS);
  localparam int CHAN_BITS  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  // Field and register widths
  localparam int LEN_BITS   = 16;
  localparam int FUNC_BITS  = 2;
  localparam int SEL_BITS   = 2;
  localparam int SLOT_OUT_BITS = 3;
  localparam int REG_IDX_BITS  = 2;

  // Reset values
  localparam logic [LEN_BITS-1:0] PEAK_RESET    = 16'd300;
  localparam logic [LEN_BITS-1:0] NEUTRAL_RESET = 16'd1500;
  localparam logic [LEN_BITS-1:0] GUARD_RESET   = 16'd10000;
  localparam logic [LEN_BITS-1:0] STEP_RESET    = 16'd10;
  localparam logic [LEN_BITS-1:0] WIDTH_MAX     = 16'hFFFF;

  // Command codes
  typedef enum logic [FUNC_BITS-1:0] {
    FUNC_NONE = 2'd0,
    FUNC_DEC  = 2'd1,
    FUNC_INC  = 2'd2,
    FUNC_RSVD = 2'd3
  } func_t;

  // Register indexes
  typedef enum logic [REG_IDX_BITS-1:0] {
    REG_PEAK    = 2'd0,
    REG_NEUTRAL = 2'd1,
    REG_GUARD   = 2'd2,
    REG_STEP    = 2'd3
  } reg_idx_t;

  // Configuration bundle
  typedef struct packed {
    logic [LEN_BITS-1:0] peak_len;
    logic [LEN_BITS-1:0] neutral_len;
    logic [LEN_BITS-1:0] guard_len;
    logic [LEN_BITS-1:0] step_len;
  } cfg_t;

  typedef logic [CHANNELS-1:0][LEN_BITS-1:0] chan_width_t;

endpackage

/* sv/pfg_if.sv */
// ----------------------------------------------------------------------------
// pfg_if
// Valid/ready channels carrying the tick command and the PPM sample result.
// ----------------------------------------------------------------------------
interface pfg_in_if
  import pfg_pkg::*;
  ();
  logic                 valid;
  logic                 ready;
  logic [FUNC_BITS-1:0] func;
  logic [SEL_BITS-1:0]  chan_sel;

  modport source (output valid, output func, output chan_sel, input ready);
  modport sink   (input valid, input func, input chan_sel, output ready);
endinterface

interface pfg_out_if
  import pfg_pkg::*;
  ();
  logic                     valid;
  logic                     ready;
  logic                     pulse;
  logic [SLOT_OUT_BITS-1:0] slot;

  modport source (output valid, output pulse, output slot, input ready);
  modport sink   (input valid, input pulse, input slot, output ready);
endinterface

/* sv/pfg_width.sv */
// ----------------------------------------------------------------------------
// pfg_width
// Adjustable channel widths: saturating raise and lower by the step length.
// ----------------------------------------------------------------------------
module pfg_width
  import pfg_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 accept,
  input  logic [FUNC_BITS-1:0] func,
  input  logic [SEL_BITS-1:0]  chan_sel,
  input  logic [LEN_BITS-1:0]  step_len,
  output chan_width_t          widths
);

  chan_width_t         widths_next;
  logic [LEN_BITS-1:0] w_cur;
  logic [LEN_BITS:0]   w_sum;
  logic                sel_ok;

  // Work out the adjusted width of the selected channel
  always_comb begin
    sel_ok      = (32'(chan_sel) < CHANNELS);
    w_cur       = widths[chan_sel[CHAN_BITS-1:0]];
    w_sum       = {1'b0, w_cur} + {1'b0, step_len};
    widths_next = widths;
    if (sel_ok) begin
      unique case (func_t'(func))
        FUNC_DEC: begin
          widths_next[chan_sel[CHAN_BITS-1:0]] =
            (w_cur > step_len) ? (w_cur - step_len) : '0;
        end
        FUNC_INC: begin
          widths_next[chan_sel[CHAN_BITS-1:0]] =
            (w_sum > {1'b0, WIDTH_MAX}) ? WIDTH_MAX : w_sum[LEN_BITS-1:0];
        end
        default: ;
      endcase
    end
  end

  // Reload from the neutral length at reset, update on each accepted beat
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < CHANNELS; i++) begin
        widths[i] <= NEUTRAL_RESET;
      end
    end else if (accept) begin
      widths <= widths_next;
    end
  end

endmodule

/* sv/pfg_timing.sv */
// ----------------------------------------------------------------------------
// pfg_timing
// Sample counter and slot sequencer; produces the pulse and slot of a tick.
// ----------------------------------------------------------------------------
module pfg_timing
  import pfg_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     accept,
  input  cfg_t                     cfg,
  input  chan_width_t              widths,
  output logic                     pulse_next,
  output logic [SLOT_OUT_BITS-1:0] slot_next_out
);

  localparam int CMP_BITS = (COUNT_BITS + 1 > LEN_BITS) ? COUNT_BITS + 1 : LEN_BITS;
  localparam logic [CMP_BITS-1:0] COUNT_MAX = CMP_BITS'({COUNT_BITS{1'b1}});

  logic [COUNT_BITS-1:0] sample_count;
  logic [COUNT_BITS-1:0] sample_count_next;
  logic [SLOT_BITS-1:0]  slot_index;
  logic [SLOT_BITS-1:0]  slot_index_next;
  logic [SLOT_BITS-1:0]  slot_cur;
  logic [CMP_BITS-1:0]   count_inc;
  logic [LEN_BITS-1:0]   slot_len;

  // Advance the count, pick the slot length and decide on slot end
  always_comb begin
    count_inc  = CMP_BITS'(sample_count) + CMP_BITS'(1);
    pulse_next = (count_inc < CMP_BITS'(cfg.peak_len));
    slot_cur   = (32'(slot_index) >= SLOTS) ? '0 : slot_index;

    if (32'(slot_cur) < CHANNELS) begin
      slot_len = widths[slot_cur[CHAN_BITS-1:0]];
    end else if (32'(slot_cur) == CHANNELS) begin
      slot_len = cfg.neutral_len;
    end else begin
      slot_len = cfg.guard_len;
    end

    if (count_inc > CMP_BITS'(slot_len)) begin
      sample_count_next = '0;
      slot_index_next   = (32'(slot_cur) == SLOTS - 1) ? '0
                                                       : slot_cur + SLOT_BITS'(1);
    end else begin
      sample_count_next = (count_inc > COUNT_MAX) ? COUNT_MAX[COUNT_BITS-1:0]
                                                  : count_inc[COUNT_BITS-1:0];
      slot_index_next   = slot_cur;
    end

    slot_next_out = SLOT_OUT_BITS'(slot_index_next);
  end

  // Hold counter and slot between accepted beats
  always_ff @(posedge clk) begin
    if (rst) begin
      sample_count <= '0;
      slot_index   <= '0;
    end else if (accept) begin
      sample_count <= sample_count_next;
      slot_index   <= slot_index_next;
    end
  end

endmodule

/* sv/ppm_frame_generator_unit.sv */
// ----------------------------------------------------------------------------
// ppm_frame_generator_unit
// RC pulse position modulator: one output sample per accepted tick beat.
// ----------------------------------------------------------------------------
// Each accepted input beat is one sample tick with an optional width command.
// The block takes one beat every clock cycle unless the output register is held
// full, and returns its result in the next cycle from the output register; a
// beat is taken whenever that register is empty or being emptied in the same
// cycle, so throughput is one item per cycle while the receiver takes results.
// Configuration writes land immediately; writing neutral_len does not reload
// the channel widths, only reset does.
module ppm_frame_generator_unit
  import pfg_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  pfg_in_if.sink                  sample_in,
  pfg_out_if.source               sample_out,
  input  logic                    cfg_we,
  input  logic [REG_IDX_BITS-1:0] cfg_index,
  input  logic [LEN_BITS-1:0]     cfg_data
);

  cfg_t                     cfg;
  chan_width_t              widths;
  logic                     accept;
  logic                     pulse_next;
  logic [SLOT_OUT_BITS-1:0] slot_next;
  logic                     out_valid;
  logic                     out_pulse;
  logic [SLOT_OUT_BITS-1:0] out_slot;

  // Take a beat while the result register is free or draining
  assign sample_in.ready = !out_valid || sample_out.ready;
  assign accept          = sample_in.valid && sample_in.ready;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.peak_len    <= PEAK_RESET;
      cfg.neutral_len <= NEUTRAL_RESET;
      cfg.guard_len   <= GUARD_RESET;
      cfg.step_len    <= STEP_RESET;
    end else if (cfg_we) begin
      unique case (reg_idx_t'(cfg_index))
        REG_PEAK:    cfg.peak_len    <= cfg_data;
        REG_NEUTRAL: cfg.neutral_len <= cfg_data;
        REG_GUARD:   cfg.guard_len   <= cfg_data;
        REG_STEP:    cfg.step_len    <= cfg_data;
        default: ;
      endcase
    end
  end

  pfg_timing u_timing (
    .clk           (clk),
    .rst           (rst),
    .accept        (accept),
    .cfg           (cfg),
    .widths        (widths),
    .pulse_next    (pulse_next),
    .slot_next_out (slot_next)
  );

  pfg_width u_width (
    .clk      (clk),
    .rst      (rst),
    .accept   (accept),
    .func     (sample_in.func),
    .chan_sel (sample_in.chan_sel),
    .step_len (cfg.step_len),
    .widths   (widths)
  );

  // Result register: load on accept, drop valid once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (sample_out.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_pulse <= pulse_next;
      out_slot  <= slot_next;
    end
  end

  assign sample_out.valid = out_valid;
  assign sample_out.pulse = out_pulse;
  assign sample_out.slot  = out_slot;

endmodule

/* dv/testbench.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the PPM frame generator unit.
// Drives sample ticks with width commands over the valid/ready input channel,
// keeps its own model of the counter, slot and channel widths, and compares
// every output beat against the oldest predicted sample. Both channels idle
// at random; the run covers register extremes, width saturation, a receiver
// hold-off that fills the block, and a channel slot held at the largest width.
// ----------------------------------------------------------------------------
module testbench;
  import pfg_pkg::*;

  localparam int STALL_LIMIT = 5000;
  localparam int HOLD_CYCLES = 400;
  localparam int COUNT_MAX   = (1 << COUNT_BITS) - 1;
  localparam int LEN_MAX     = (1 << LEN_BITS) - 1;

  typedef struct {
    logic                     pulse;
    logic [SLOT_OUT_BITS-1:0] slot;
  } ppm_sample_t;

  logic                    clk;
  logic                    rst;
  logic                    cfg_we;
  logic [REG_IDX_BITS-1:0] cfg_index;
  logic [LEN_BITS-1:0]     cfg_data;

  pfg_in_if  in_ch ();
  pfg_out_if out_ch ();

  ppm_frame_generator_unit dut (
    .clk        (clk),
    .rst        (rst),
    .sample_in  (in_ch),
    .sample_out (out_ch),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  // Frame state mirrored from the block
  int          smp_count;
  int          cur_slot;
  int          chan_len [CHANNELS];
  int          cfg_peak;
  int          cfg_neutral;
  int          cfg_guard;
  int          cfg_step;

  ppm_sample_t expected_samples [$];
  int          fault_count;
  int          stall_cycles;
  bit          in_idle_on;
  bit          out_idle_on;
  int          hold_req;

  // Clock
  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // Advance the frame by one tick, then apply the width command
  function automatic ppm_sample_t next_sample(input func_t f, input logic [SEL_BITS-1:0] sel);
    ppm_sample_t s;
    int          nxt;
    int          len;
    int          w;
    nxt = smp_count + 1;
    s.pulse = (nxt < cfg_peak);
    if (cur_slot < CHANNELS) len = chan_len[cur_slot];
    else if (cur_slot == CHANNELS) len = cfg_neutral;
    else len = cfg_guard;
    if (nxt > len) begin
      smp_count = 0;
      cur_slot  = (cur_slot + 1) % SLOTS;
    end else begin
      smp_count = (nxt > COUNT_MAX) ? COUNT_MAX : nxt;
    end
    if (int'(sel) < CHANNELS) begin
      w = chan_len[sel];
      if (f == FUNC_DEC) w = (w > cfg_step) ? w - cfg_step : 0;
      else if (f == FUNC_INC) w = (w + cfg_step > LEN_MAX) ? LEN_MAX : w + cfg_step;
      chan_len[sel] = w;
    end
    s.slot = cur_slot[SLOT_OUT_BITS-1:0];
    return s;
  endfunction

  // Offer one tick beat, idling first at random; record the prediction on acceptance
  task automatic send_tick(input func_t f, input logic [SEL_BITS-1:0] sel);
    bit taken;
    taken = 1'b0;
    while (in_idle_on && $urandom_range(0, 99) < 23) begin
      @(negedge clk);
      in_ch.valid <= 1'b0;
    end
    @(negedge clk);
    in_ch.valid    <= 1'b1;
    in_ch.func     <= f;
    in_ch.chan_sel <= sel;
    while (!taken) begin
      @(posedge clk);
      if (in_ch.ready) begin
        taken = 1'b1;
        expected_samples.push_back(next_sample(f, sel));
      end
    end
  endtask

  // Drop valid and hold until every predicted sample has come back
  task automatic drain_results();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (expected_samples.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic write_reg(input reg_idx_t idx, input logic [LEN_BITS-1:0] v);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= v;
    case (idx)
      REG_PEAK:    cfg_peak    = int'(v);
      REG_NEUTRAL: cfg_neutral = int'(v);
      REG_GUARD:   cfg_guard   = int'(v);
      REG_STEP:    cfg_step    = int'(v);
      default: ;
    endcase
  endtask

  task automatic program_config(input logic [LEN_BITS-1:0] peak, input logic [LEN_BITS-1:0] neutral,
                                input logic [LEN_BITS-1:0] guard, input logic [LEN_BITS-1:0] step);
    drain_results();
    write_reg(REG_PEAK, peak);
    write_reg(REG_NEUTRAL, neutral);
    write_reg(REG_GUARD, guard);
    write_reg(REG_STEP, step);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic func_t pick_func();
    int r;
    r = $urandom_range(0, 99);
    if (r < 35) return FUNC_NONE;
    if (r < 65) return FUNC_DEC;
    if (r < 90) return FUNC_INC;
    return FUNC_RSVD;
  endfunction

  // Every command against every channel under reset settings
  task automatic test_reset_defaults();
    for (int f = 0; f < 4; f++) begin
      for (int c = 0; c < 4; c++) begin
        send_tick(func_t'(f), c[SEL_BITS-1:0]);
      end
    end
  endtask

  // Full-range step drives widths into both saturation limits; zero lengths
  // advance the slot on every tick and a zero peak keeps the pulse low
  task automatic test_width_saturation();
    program_config(16'd0, 16'd0, 16'd0, 16'hFFFF);
    for (int c = 0; c < CHANNELS; c++) send_tick(FUNC_DEC, c[SEL_BITS-1:0]);
    send_tick(FUNC_INC, 2'd1);
    send_tick(FUNC_INC, 2'd1);
    send_tick(FUNC_DEC, 2'd1);
    send_tick(FUNC_DEC, 2'd1);
  endtask

  task automatic run_random_ticks(input int n);
    for (int i = 0; i < n; i++) begin
      send_tick(pick_func(), SEL_BITS'($urandom_range(0, 3)));
    end
  endtask

  // Short frames with random commands under several register settings
  task automatic test_random_frames();
    logic [LEN_BITS-1:0] set_list [5][4];
    set_list[0] = '{16'd3, 16'd5, 16'd9, 16'd1};
    set_list[1] = '{16'd0, 16'd2, 16'd4, 16'd2};
    set_list[2] = '{16'd8, 16'd12, 16'd20, 16'd3};
    set_list[3] = '{16'd2, 16'd3, 16'd6, 16'd1};
    set_list[4] = '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF};
    for (int k = 0; k < 5; k++) begin
      program_config(set_list[k][0], set_list[k][1], set_list[k][2], set_list[k][3]);
      // one phase runs with no idling on either side
      in_idle_on  = (k != 3);
      out_idle_on = (k != 3);
      run_random_ticks(300);
    end
    in_idle_on  = 1'b1;
    out_idle_on = 1'b1;
  endtask

  // Receiver holds off while ticks keep coming, then the sender waits it out
  task automatic test_backpressure();
    program_config(16'd4, 16'd6, 16'd10, 16'd2);
    for (int c = 0; c < CHANNELS; c++) send_tick(FUNC_DEC, c[SEL_BITS-1:0]);
    hold_req   = HOLD_CYCLES;
    in_idle_on = 1'b0;
    run_random_ticks(40);
    in_idle_on = 1'b1;
    drain_results();
    run_random_ticks(20);
  endtask

  // A channel slot at the largest width holds its slot with the pulse high
  task automatic test_full_length_slot();
    program_config(16'hFFFF, 16'd0, 16'd0, 16'hFFFF);
    for (int c = 0; c < CHANNELS; c++) send_tick(FUNC_DEC, c[SEL_BITS-1:0]);
    send_tick(FUNC_INC, 2'd0);
    in_idle_on  = 1'b0;
    out_idle_on = 1'b0;
    for (int i = 0; i < 40; i++) send_tick(FUNC_NONE, 2'd3);
    in_idle_on  = 1'b1;
    out_idle_on = 1'b1;
    program_config(PEAK_RESET, NEUTRAL_RESET, GUARD_RESET, STEP_RESET);
    run_random_ticks(60);
  endtask

  // Receiver: random idling, or a counted hold-off on request
  initial begin
    int n;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req > 0) begin
        n        = hold_req;
        hold_req = 0;
        out_ch.ready <= 1'b0;
        repeat (n - 1) @(negedge clk);
      end else begin
        out_ch.ready <= !out_idle_on || ($urandom_range(0, 99) >= 23);
      end
    end
  end

  // Compare each output beat with the oldest prediction
  always @(posedge clk) begin
    ppm_sample_t want;
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (expected_samples.size() == 0) begin
        fault_count++;
        if (fault_count <= 10)
          $display("unexpected sample: pulse=%0b slot=%0d", out_ch.pulse, out_ch.slot);
      end else begin
        want = expected_samples.pop_front();
        if (out_ch.pulse !== want.pulse || out_ch.slot !== want.slot) begin
          fault_count++;
          if (fault_count <= 10)
            $display("sample mismatch: expected pulse=%0b slot=%0d, got pulse=%0b slot=%0d",
                     want.pulse, want.slot, out_ch.pulse, out_ch.slot);
        end
      end
    end
  end

  // Watchdog on cycles without any beat
  always @(posedge clk) begin
    if (rst || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    rst            = 1'b1;
    in_ch.valid    = 1'b0;
    in_ch.func     = FUNC_NONE;
    in_ch.chan_sel = '0;
    cfg_we         = 1'b0;
    cfg_index      = REG_PEAK;
    cfg_data       = '0;
    fault_count    = 0;
    stall_cycles   = 0;
    hold_req       = 0;
    in_idle_on     = 1'b1;
    out_idle_on    = 1'b1;
    smp_count      = 0;
    cur_slot       = 0;
    cfg_peak       = int'(PEAK_RESET);
    cfg_neutral    = int'(NEUTRAL_RESET);
    cfg_guard      = int'(GUARD_RESET);
    cfg_step       = int'(STEP_RESET);
    for (int c = 0; c < CHANNELS; c++) chan_len[c] = int'(NEUTRAL_RESET);
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_reset_defaults();
    test_width_saturation();
    test_random_frames();
    test_backpressure();
    test_full_length_slot();

    drain_results();
    repeat (8) @(posedge clk);
    if (expected_samples.size() != 0) fault_count++;
    if (fault_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
